/* src/wde_pkg.sv */
package wde_pkg;

  // fixed field widths of the channels
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned TS_W    = 32;
  localparam int unsigned DELAY_W = 32;
  localparam int unsigned LVL_W   = 7;
  localparam int unsigned WSIZE_W = 7;

  // window size after reset
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd64;

  // a delay is suggested once drops reach one in this many entries
  localparam int unsigned DROP_RATIO = 20;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_DROP  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [8:0] {
    S_SWEEP   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_LOOKUP  = 9'b000000100,
    S_RETIRE  = 9'b000001000,
    S_RETDATA = 9'b000010000,
    S_PUSH    = 9'b000100000,
    S_CHECK   = 9'b001000000,
    S_DIV     = 9'b010000000,
    S_FIN     = 9'b100000000
  } state_e;

endpackage

/* src/wde_in_if.sv */
interface wde_in_if;
  logic                      valid;
  logic                      ready;
  logic [wde_pkg::CMD_W-1:0] command;
  logic [wde_pkg::ID_W-1:0]  chunk_id;
  logic [wde_pkg::TS_W-1:0]  timestamp_ms;

  modport source (output valid, command, chunk_id, timestamp_ms, input ready);
  modport sink   (input valid, command, chunk_id, timestamp_ms, output ready);
endinterface

/* src/wde_out_if.sv */
interface wde_out_if;
  logic                        valid;
  logic                        ready;
  logic [wde_pkg::DELAY_W-1:0] ideal_delay;
  logic                        matched;
  logic [wde_pkg::LVL_W-1:0]   drops_in_window;
  logic [wde_pkg::LVL_W-1:0]   fill_level;

  modport source (output valid, ideal_delay, matched, drops_in_window, fill_level,
                  input ready);
  modport sink   (input valid, ideal_delay, matched, drops_in_window, fill_level,
                  output ready);
endinterface

/* src/windowed_delay_estimator.sv */
// channel   dir  handshake      payload
// in_i      in   valid/ready    command, chunk_id, timestamp_ms
// out_o     out  valid/ready    ideal_delay, matched, drops_in_window, fill_level
// cfg       in   cfg_we_i       cfg_wdata_i = window_size
//
// per item: take, lookup, retire check plus a retire step per retired entry, push, check,
// divide when a delay is due, then load.
// after reset and after each clear the whole start table is swept, with ready low.
// a finished result waits in the output register while the next beat is taken.
module windowed_delay_estimator #(
  parameter int unsigned WINDOW_DEPTH = 64,
  parameter int unsigned ID_BITS      = 8,
  parameter int unsigned TIME_BITS    = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [wde_pkg::WSIZE_W-1:0] cfg_wdata_i,
  wde_in_if.sink                      in_i,
  wde_out_if.source                   out_o
);

  localparam int unsigned PTR_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SLOT_W  = PTR_W + 1;
  localparam int unsigned SZ_W    = (CNT_W > wde_pkg::WSIZE_W) ? CNT_W : wde_pkg::WSIZE_W;
  localparam int unsigned RT_W    = CNT_W + 5;
  localparam int unsigned SUM_W   = TIME_BITS + CNT_W;
  localparam int unsigned STEP_W  = $clog2(SUM_W);
  localparam int unsigned ID_CNT  = 1 << ID_BITS;

  // start table: valid flag over start time
  logic [TIME_BITS:0] st_mem [ID_CNT];
  logic [TIME_BITS:0] st_rd_q;
  logic               st_we;
  logic [ID_BITS-1:0] st_waddr;
  logic [TIME_BITS:0] st_wdata;
  logic [ID_BITS-1:0] st_raddr;

  // window ring: drop flag over processing time
  logic [TIME_BITS:0] win_mem [WINDOW_DEPTH];
  logic [TIME_BITS:0] win_rd_q;
  logic               win_we;
  logic [PTR_W-1:0]   win_waddr;
  logic [TIME_BITS:0] win_wdata;

  // control state
  wde_pkg::state_e             state_q, state_d;
  logic [wde_pkg::WSIZE_W-1:0] wsize_q, wsize_d;
  logic [PTR_W-1:0]            oldest_q, oldest_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [CNT_W-1:0]            drops_q, drops_d;
  logic [SUM_W-1:0]            sum_q, sum_d;
  logic [ID_BITS-1:0]          sw_q, sw_d;
  logic                        clr_q, clr_d;
  logic                        out_valid_q, out_valid_d;

  // item payload and divider
  wde_pkg::cmd_e               cmd_q, cmd_d;
  logic [ID_BITS-1:0]          id_q, id_d;
  logic [TIME_BITS-1:0]        now_q, now_d;
  logic [TIME_BITS-1:0]        ptime_q, ptime_d;
  logic                        matched_q, matched_d;
  logic [SUM_W-1:0]            quo_q, quo_d;
  logic [CNT_W-1:0]            rem_q, rem_d;
  logic [STEP_W-1:0]           step_q, step_d;
  logic [wde_pkg::DELAY_W-1:0] delay_q, delay_d;
  logic                        omatch_q, omatch_d;
  logic [wde_pkg::LVL_W-1:0]   odrops_q, odrops_d;
  logic [wde_pkg::LVL_W-1:0]   ofill_q, ofill_d;

  // helpers
  logic [SZ_W-1:0]   wsz_ext;
  logic [CNT_W-1:0]  eff_size;
  logic [SLOT_W-1:0] slot_sum;
  logic [PTR_W-1:0]  slot;
  logic [RT_W-1:0]   drops_x20;
  logic              delay_due;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    divisor;
  logic              trial_ge;
  logic              st_hit;

  // window size clamped to 1..WINDOW_DEPTH
  always_comb begin
    wsz_ext = SZ_W'(wsize_q);
    if (wsz_ext == '0) begin
      eff_size = CNT_W'(1);
    end else if (wsz_ext > SZ_W'(WINDOW_DEPTH)) begin
      eff_size = CNT_W'(WINDOW_DEPTH);
    end else begin
      eff_size = CNT_W'(wsz_ext);
    end
  end

  // next free slot of the ring
  assign slot_sum = SLOT_W'(oldest_q) + SLOT_W'(count_q);
  assign slot     = (slot_sum >= SLOT_W'(WINDOW_DEPTH))
                    ? PTR_W'(slot_sum - SLOT_W'(WINDOW_DEPTH)) : PTR_W'(slot_sum);

  // 5% drop test in integers
  assign drops_x20 = (RT_W'(drops_q) << 4) + (RT_W'(drops_q) << 2);
  assign delay_due = (count_q != '0) && (drops_x20 >= RT_W'(count_q));

  // one restoring divider step
  assign divisor  = {1'b0, count_q};
  assign trial    = {rem_q, quo_q[SUM_W-1]};
  assign trial_ge = (trial >= divisor);

  assign st_hit   = st_rd_q[TIME_BITS];
  assign st_raddr = ID_BITS'(in_i.chunk_id);

  assign in_i.ready            = (state_q == wde_pkg::S_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.ideal_delay     = delay_q;
  assign out_o.matched         = omatch_q;
  assign out_o.drops_in_window = odrops_q;
  assign out_o.fill_level      = ofill_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    wsize_d     = cfg_we_i ? cfg_wdata_i : wsize_q;
    oldest_d    = oldest_q;
    count_d     = count_q;
    drops_d     = drops_q;
    sum_d       = sum_q;
    sw_d        = sw_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_o.ready;
    cmd_d       = cmd_q;
    id_d        = id_q;
    now_d       = now_q;
    ptime_d     = ptime_q;
    matched_d   = matched_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    step_d      = step_q;
    delay_d     = delay_q;
    omatch_d    = omatch_q;
    odrops_d    = odrops_q;
    ofill_d     = ofill_q;
    st_we       = 1'b0;
    st_waddr    = id_q;
    st_wdata    = '0;
    win_we      = 1'b0;
    win_waddr   = slot;
    win_wdata   = '0;

    case (state_q)
      // clear the start table one entry a cycle
      wde_pkg::S_SWEEP: begin
        st_we    = 1'b1;
        st_waddr = sw_q;
        sw_d     = sw_q + 1'b1;
        if (sw_q == '1) begin
          state_d = wde_pkg::S_IDLE;
        end
      end
      // take a beat, start table read is in flight
      wde_pkg::S_IDLE: begin
        if (in_i.valid) begin
          cmd_d   = wde_pkg::cmd_e'(in_i.command);
          id_d    = ID_BITS'(in_i.chunk_id);
          now_d   = TIME_BITS'(in_i.timestamp_ms);
          clr_d   = 1'b0;
          state_d = wde_pkg::S_LOOKUP;
        end
      end
      // start table data is here
      wde_pkg::S_LOOKUP: begin
        matched_d = 1'b0;
        state_d   = wde_pkg::S_CHECK;
        case (cmd_q)
          wde_pkg::CMD_START: begin
            if (!st_hit) begin
              st_we     = 1'b1;
              st_wdata  = {1'b1, now_q};
              matched_d = 1'b1;
            end
          end
          wde_pkg::CMD_ACK, wde_pkg::CMD_DROP: begin
            if (st_hit) begin
              st_we     = 1'b1;
              st_wdata  = {1'b0, st_rd_q[TIME_BITS-1:0]};
              matched_d = 1'b1;
              ptime_d   = now_q - st_rd_q[TIME_BITS-1:0];
              state_d   = wde_pkg::S_RETIRE;
            end
          end
          wde_pkg::CMD_CLEAR: begin
            oldest_d = '0;
            count_d  = '0;
            drops_d  = '0;
            sum_d    = '0;
            clr_d    = 1'b1;
          end
          default: begin
            state_d = wde_pkg::S_CHECK;
          end
        endcase
      end
      // make room, ring read of the oldest entry is issued here
      wde_pkg::S_RETIRE: begin
        if (count_q >= eff_size) begin
          state_d = wde_pkg::S_RETDATA;
        end else begin
          state_d = wde_pkg::S_PUSH;
        end
      end
      // drop the oldest entry from the totals
      wde_pkg::S_RETDATA: begin
        if (win_rd_q[TIME_BITS]) begin
          drops_d = drops_q - 1'b1;
        end else begin
          sum_d = sum_q - SUM_W'(win_rd_q[TIME_BITS-1:0]);
        end
        oldest_d = (oldest_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
        count_d  = count_q - 1'b1;
        state_d  = wde_pkg::S_RETIRE;
      end
      // append the outcome
      wde_pkg::S_PUSH: begin
        win_we  = 1'b1;
        count_d = count_q + 1'b1;
        if (cmd_q == wde_pkg::CMD_DROP) begin
          win_wdata = {1'b1, {TIME_BITS{1'b0}}};
          drops_d   = drops_q + 1'b1;
        end else begin
          win_wdata = {1'b0, ptime_q};
          sum_d     = sum_q + SUM_W'(ptime_q);
        end
        state_d = wde_pkg::S_CHECK;
      end
      // decide whether an average is needed
      wde_pkg::S_CHECK: begin
        rem_d  = '0;
        step_d = '0;
        if (delay_due) begin
          quo_d   = sum_q;
          state_d = wde_pkg::S_DIV;
        end else begin
          quo_d   = '0;
          state_d = wde_pkg::S_FIN;
        end
      end
      // one quotient bit per cycle
      wde_pkg::S_DIV: begin
        rem_d  = trial_ge ? CNT_W'(trial - divisor) : CNT_W'(trial);
        quo_d  = {quo_q[SUM_W-2:0], trial_ge};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(SUM_W - 1)) begin
          state_d = wde_pkg::S_FIN;
        end
      end
      // load the output register once it is free
      wde_pkg::S_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          delay_d     = wde_pkg::DELAY_W'(quo_q);
          omatch_d    = matched_q;
          odrops_d    = wde_pkg::LVL_W'(drops_q);
          ofill_d     = wde_pkg::LVL_W'(count_q);
          state_d     = clr_q ? wde_pkg::S_SWEEP : wde_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wde_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wde_pkg::S_SWEEP;
      wsize_q     <= wde_pkg::WSIZE_RESET;
      oldest_q    <= '0;
      count_q     <= '0;
      drops_q     <= '0;
      sum_q       <= '0;
      sw_q        <= '0;
      clr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wsize_q     <= wsize_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      drops_q     <= drops_d;
      sum_q       <= sum_d;
      sw_q        <= sw_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    id_q      <= id_d;
    now_q     <= now_d;
    ptime_q   <= ptime_d;
    matched_q <= matched_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    step_q    <= step_d;
    delay_q   <= delay_d;
    omatch_q  <= omatch_d;
    odrops_q  <= odrops_d;
    ofill_q   <= ofill_d;
  end

  // start table memory
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rd_q <= st_mem[st_raddr];
  end

  // window ring memory
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[win_waddr] <= win_wdata;
    end
    win_rd_q <= win_mem[oldest_q];
  end

endmodule

/* verif/wde_delay_checker.sv */
module wde_delay_checker #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [wde_pkg::WSIZE_W-1:0] cfg_wdata_i,
  wde_in_if                           in_i,
  wde_out_if                          out_i,
  output int unsigned                 errors_o,
  output int unsigned                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ID_COUNT = 1 << wde_pkg::ID_W;

  typedef struct packed {
    logic [wde_pkg::DELAY_W-1:0] ideal_delay;
    logic                        matched;
    logic [wde_pkg::LVL_W-1:0]   drops_in_window;
    logic [wde_pkg::LVL_W-1:0]   fill_level;
  } delay_result_t;

  // shadow copy of the block state
  logic [wde_pkg::TS_W-1:0]    chunk_start [ID_COUNT];
  bit                          chunk_open  [ID_COUNT];
  bit                          slot_dropped [WINDOW_DEPTH];
  logic [wde_pkg::TS_W-1:0]    slot_time    [WINDOW_DEPTH];
  int unsigned                 oldest_slot;
  int unsigned                 window_fill;
  int unsigned                 drop_count;
  logic [37:0]                 time_sum;
  logic [wde_pkg::WSIZE_W-1:0] window_size_q;

  delay_result_t expected_delays [$];
  int unsigned   mismatches = 0;

  // empty the start table and the window
  function automatic void clear_window();
    for (int i = 0; i < ID_COUNT; i++) chunk_open[i] = 1'b0;
    oldest_slot = 0;
    window_fill = 0;
    drop_count  = 0;
    time_sum    = '0;
  endfunction

  // advance the shadow state by one command and return its result
  function automatic delay_result_t predict_delay_step(wde_pkg::cmd_e cmd,
                                                       logic [wde_pkg::ID_W-1:0] id,
                                                       logic [wde_pkg::TS_W-1:0] ts);
    delay_result_t            res;
    int unsigned              limit;
    int unsigned              slot;
    logic [wde_pkg::TS_W-1:0] elapsed;
    logic [37:0]              avg;
    res = '0;
    case (cmd)
      wde_pkg::CMD_START: begin
        if (!chunk_open[id]) begin
          chunk_open[id]  = 1'b1;
          chunk_start[id] = ts;
          res.matched     = 1'b1;
        end
      end
      wde_pkg::CMD_ACK, wde_pkg::CMD_DROP: begin
        if (chunk_open[id]) begin
          res.matched    = 1'b1;
          chunk_open[id] = 1'b0;
          if (window_size_q == 0) limit = 1;
          else if (window_size_q > WINDOW_DEPTH) limit = WINDOW_DEPTH;
          else limit = window_size_q;
          // retire the oldest entries until there is room
          while (window_fill >= limit) begin
            if (slot_dropped[oldest_slot]) drop_count--;
            else time_sum = time_sum - 38'(slot_time[oldest_slot]);
            oldest_slot = (oldest_slot + 1) % WINDOW_DEPTH;
            window_fill--;
          end
          slot = (oldest_slot + window_fill) % WINDOW_DEPTH;
          slot_dropped[slot] = (cmd == wde_pkg::CMD_DROP);
          if (cmd == wde_pkg::CMD_DROP) begin
            slot_time[slot] = '0;
            drop_count++;
          end else begin
            elapsed         = ts - chunk_start[id];
            slot_time[slot] = elapsed;
            time_sum        = time_sum + 38'(elapsed);
          end
          window_fill++;
        end
      end
      default: clear_window();
    endcase
    // delay only once drops reach the ratio threshold
    if (window_fill != 0 && wde_pkg::DROP_RATIO * drop_count >= window_fill) begin
      avg = time_sum / 38'(window_fill);
      res.ideal_delay = avg[wde_pkg::DELAY_W-1:0];
    end
    res.drops_in_window = wde_pkg::LVL_W'(drop_count);
    res.fill_level      = wde_pkg::LVL_W'(window_fill);
    return res;
  endfunction

  // compare result beats, then predict from input beats
  always @(posedge clk_i or negedge rst_ni) begin
    delay_result_t want;
    if (!rst_ni) begin
      window_size_q = wde_pkg::WSIZE_RESET;
      clear_window();
      expected_delays.delete();
    end else begin
      if (out_i.valid === 1'b1 && out_i.ready === 1'b1) begin
        if (expected_delays.size() == 0) begin
          $error("result beat with no expected result waiting");
          mismatches++;
        end else begin
          want = expected_delays[0];
          expected_delays.delete(0);
          if (out_i.ideal_delay !== want.ideal_delay) begin
            $error("ideal_delay: expected %0d, actual %0d", want.ideal_delay,
                   out_i.ideal_delay);
            mismatches++;
          end
          if (out_i.matched !== want.matched) begin
            $error("matched: expected %0d, actual %0d", want.matched, out_i.matched);
            mismatches++;
          end
          if (out_i.drops_in_window !== want.drops_in_window) begin
            $error("drops_in_window: expected %0d, actual %0d", want.drops_in_window,
                   out_i.drops_in_window);
            mismatches++;
          end
          if (out_i.fill_level !== want.fill_level) begin
            $error("fill_level: expected %0d, actual %0d", want.fill_level,
                   out_i.fill_level);
            mismatches++;
          end
        end
      end
      if (cfg_we_i === 1'b1) window_size_q = cfg_wdata_i;
      if (in_i.valid === 1'b1 && in_i.ready === 1'b1) begin
        expected_delays.push_back(predict_delay_step(wde_pkg::cmd_e'(in_i.command),
                                                     in_i.chunk_id, in_i.timestamp_ms));
      end
    end
    pending_o = expected_delays.size();
    errors_o  = mismatches;
  end

endmodule

/* verif/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [wde_pkg::WSIZE_W-1:0] cfg_wdata_i;
  int unsigned                 errors;
  int unsigned                 pending;

  wde_in_if  in_if ();
  wde_out_if out_if ();

  windowed_delay_estimator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  wde_delay_checker delay_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_i       (out_if),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // chunks started by the stimulus and not yet resolved
  logic [wde_pkg::ID_W-1:0] open_ids [$];
  bit                       id_open [1 << wde_pkg::ID_W];
  logic [wde_pkg::TS_W-1:0] now_ms;
  int unsigned              hold_requests = 0;

  // clock, 2 ns period
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: stall modes of random length, plus requested long hold-offs
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned holds_seen;
    int unsigned cyc;
    mode       = 0;
    mode_left  = 0;
    hold_left  = 0;
    holds_seen = 0;
    cyc        = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left  = 800;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 200);
        end
        mode_left--;
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= ($urandom_range(0, 7) == 0);
          default: out_if.ready <= ((cyc % 5) != 0);
        endcase
      end
    end
  end

  // one input beat, held until accepted
  task automatic send_item(input wde_pkg::cmd_e cmd, input logic [wde_pkg::ID_W-1:0] id,
                           input logic [wde_pkg::TS_W-1:0] ts);
    @(negedge clk_i);
    in_if.valid        <= 1'b1;
    in_if.command      <= cmd;
    in_if.chunk_id     <= id;
    in_if.timestamp_ms <= ts;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
  endtask

  // mostly start/outcome pairs of tracked chunks, some noise and clears
  task automatic send_random_item(input int unsigned drop_pct);
    int unsigned              r;
    int unsigned              idx;
    wde_pkg::cmd_e            cmd;
    logic [wde_pkg::ID_W-1:0] id;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) now_ms = $urandom();
    else now_ms = now_ms + $urandom_range(0, 40);
    if (r == 0) begin
      cmd = wde_pkg::CMD_CLEAR;
      id  = wde_pkg::ID_W'($urandom_range(0, 255));
    end else if (r < 9) begin
      cmd = wde_pkg::cmd_e'($urandom_range(0, 2));
      id  = wde_pkg::ID_W'($urandom_range(0, 255));
    end else if (open_ids.size() == 0 || (r < 55 && open_ids.size() < 40)) begin
      cmd = wde_pkg::CMD_START;
      id  = wde_pkg::ID_W'($urandom_range(0, 255));
    end else begin
      idx = $urandom_range(0, open_ids.size() - 1);
      id  = open_ids[idx];
      cmd = ($urandom_range(0, 99) < drop_pct) ? wde_pkg::CMD_DROP : wde_pkg::CMD_ACK;
    end
    // keep the stimulus view of open chunks in step
    case (cmd)
      wde_pkg::CMD_START: begin
        if (!id_open[id]) begin
          id_open[id] = 1'b1;
          open_ids.push_back(id);
        end
      end
      wde_pkg::CMD_CLEAR: begin
        open_ids.delete();
        for (int i = 0; i < (1 << wde_pkg::ID_W); i++) id_open[i] = 1'b0;
      end
      default: begin
        if (id_open[id]) begin
          id_open[id] = 1'b0;
          for (int i = 0; i < open_ids.size(); i++) begin
            if (open_ids[i] == id) begin
              open_ids.delete(i);
              break;
            end
          end
        end
      end
    endcase
    send_item(cmd, id, now_ms);
  endtask

  // bursts of random length with random gaps
  task automatic run_phase(input int unsigned n_items, input int unsigned drop_pct);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 40);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      repeat (burst) begin
        if (sent < n_items) begin
          send_random_item(drop_pct);
          sent++;
        end
      end
      repeat (gap) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  // register write once all results are in and the block takes input
  task automatic set_window(input logic [wde_pkg::WSIZE_W-1:0] size);
    do @(negedge clk_i); while (pending != 0 || in_if.ready !== 1'b1);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    logic [wde_pkg::WSIZE_W-1:0] sizes [10];
    sizes = '{7'd3, 7'd127, 7'd0, 7'd1, 7'd40, 7'd100, 7'd64, 7'd17, 7'd2, 7'd64};
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    in_if.valid        = 1'b0;
    in_if.command      = wde_pkg::CMD_START;
    in_if.chunk_id     = '0;
    in_if.timestamp_ms = '0;
    now_ms             = '0;
    for (int i = 0; i < (1 << wde_pkg::ID_W); i++) id_open[i] = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part at the reset window size
    send_item(wde_pkg::CMD_ACK,   8'h00, 32'h0000_0000); // ack of an unknown chunk
    send_item(wde_pkg::CMD_DROP,  8'hFF, 32'hFFFF_FFFF); // drop of an unknown chunk
    send_item(wde_pkg::CMD_START, 8'h00, 32'h0000_0000);
    send_item(wde_pkg::CMD_START, 8'h00, 32'h0000_0005); // repeated start keeps first time
    send_item(wde_pkg::CMD_START, 8'hFF, 32'hFFFF_FFF0);
    send_item(wde_pkg::CMD_ACK,   8'h00, 32'h0000_03E8);
    send_item(wde_pkg::CMD_DROP,  8'h00, 32'h0000_03E9); // already resolved
    send_item(wde_pkg::CMD_ACK,   8'hFF, 32'h0000_0010); // time wraps
    send_item(wde_pkg::CMD_START, 8'hAA, 32'hFFFF_FFFF);
    send_item(wde_pkg::CMD_DROP,  8'hAA, 32'h0000_0000); // drop mark, delay now due
    send_item(wde_pkg::CMD_START, 8'h55, 32'h0000_0000);
    send_item(wde_pkg::CMD_ACK,   8'h55, 32'hFFFF_FFFF); // largest processing time
    send_item(wde_pkg::CMD_START, 8'h0F, 32'h0000_0007);
    send_item(wde_pkg::CMD_DROP,  8'h0F, 32'h0000_0008);
    send_item(wde_pkg::CMD_START, 8'hF0, 32'h0000_0001);
    send_item(wde_pkg::CMD_CLEAR, 8'hF0, 32'h0000_0002);
    send_item(wde_pkg::CMD_ACK,   8'hF0, 32'h0000_0003); // forgotten by the clear
    send_item(wde_pkg::CMD_START, 8'hF0, 32'h0000_0004); // new again after the clear
    send_item(wde_pkg::CMD_CLEAR, 8'h00, 32'h0000_0000);
    @(negedge clk_i);
    in_if.valid <= 1'b0;

    // random phases over several window sizes, shrinking ones among them
    foreach (sizes[p]) begin
      set_window(sizes[p]);
      if (p == 1 || p == 6) hold_requests++;
      run_phase(200, $urandom_range(2, 30));
    end

    // drain
    do @(negedge clk_i); while (pending != 0);
    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
